[src/ssis_pkg.sv]
package ssis_pkg;

   localparam int CAPACITY   = 64;
   localparam int KEY_BITS   = 32;
   localparam int COUNT_BITS = $clog2(CAPACITY + 1);

   typedef logic [15:0]         handle_type;
   typedef logic [31:0]         key_field_type;
   typedef logic [KEY_BITS-1:0] key_type;
   typedef logic [COUNT_BITS-1:0] count_type;

   typedef struct packed {
      logic       valid;
      key_type    key;
      handle_type handle;
   } rec_type;

   typedef struct packed {
      logic       insert;
      logic       shift;
      key_type    key;
      handle_type handle;
   } cell_ctrl_type;

   typedef enum logic {
      ST_FILL,
      ST_DRAIN
   } state_type;

   function automatic key_type to_key(key_field_type field);
      logic [63:0] wide;
      wide = {32'b0, field};
      return wide[KEY_BITS-1:0];
   endfunction

   function automatic key_field_type from_key(key_type key);
      logic [63:0] wide;
      wide = 64'(key);
      return wide[31:0];
   endfunction

endpackage

[src/ssis_if.sv]
interface ssis_req_if import ssis_pkg::*;;
   logic          valid;
   logic          ready;
   handle_type    item_handle;
   key_field_type sort_key;
   logic          batch_end;

   modport source (output valid, item_handle, sort_key, batch_end, input ready);
   modport sink (input valid, item_handle, sort_key, batch_end, output ready);
endinterface

interface ssis_rsp_if import ssis_pkg::*;;
   logic          valid;
   logic          ready;
   handle_type    sorted_handle;
   key_field_type sorted_key;
   logic          final_flag;
   logic          overflow_flag;

   modport source (output valid, sorted_handle, sorted_key, final_flag, overflow_flag,
                   input ready);
   modport sink (input valid, sorted_handle, sorted_key, final_flag, overflow_flag,
                 output ready);
endinterface

[src/ssis_cell.sv]
module ssis_cell import ssis_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  cell_ctrl_type ctrl,
   input  rec_type       left_rec,
   input  logic          left_gt,
   input  rec_type       right_rec,
   output rec_type       rec,
   output logic          gt
);

   logic       valid_ff, valid_in;
   key_type    key_ff, key_in;
   handle_type handle_ff, handle_in;
   logic       take_new;

   assign gt       = valid_ff && (key_ff > ctrl.key);
   // strict compare: equal keys stay behind older ones
   assign take_new = !left_gt && left_rec.valid && (gt || !valid_ff);

   assign rec.valid  = valid_ff;
   assign rec.key    = key_ff;
   assign rec.handle = handle_ff;

   always_comb begin
      valid_in  = valid_ff;
      key_in    = key_ff;
      handle_in = handle_ff;
      if (ctrl.shift) begin
         valid_in  = right_rec.valid;
         key_in    = right_rec.key;
         handle_in = right_rec.handle;
      end else if (ctrl.insert) begin
         if (left_gt) begin
            valid_in  = left_rec.valid;
            key_in    = left_rec.key;
            handle_in = left_rec.handle;
         end else if (take_new) begin
            valid_in  = 1'b1;
            key_in    = ctrl.key;
            handle_in = ctrl.handle;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      key_ff    <= key_in;
      handle_ff <= handle_in;
   end

endmodule

[src/ssis_chain.sv]
module ssis_chain import ssis_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  cell_ctrl_type ctrl,
   output rec_type       head
);

   rec_type recs       [CAPACITY];
   logic    gts        [CAPACITY];
   rec_type left_recs  [CAPACITY];
   logic    left_gts   [CAPACITY];
   rec_type right_recs [CAPACITY];

   assign head = recs[0];

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      if (i == 0) begin : g_first
         // virtual occupied neighbor that never moves down
         assign left_recs[i] = '{valid: 1'b1, key: '0, handle: '0};
         assign left_gts[i]  = 1'b0;
      end else begin : g_inner
         assign left_recs[i] = recs[i-1];
         assign left_gts[i]  = gts[i-1];
      end

      if (i == CAPACITY - 1) begin : g_last
         assign right_recs[i] = '0;
      end else begin : g_body
         assign right_recs[i] = recs[i+1];
      end

      ssis_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .ctrl      (ctrl),
         .left_rec  (left_recs[i]),
         .left_gt   (left_gts[i]),
         .right_rec (right_recs[i]),
         .rec       (recs[i]),
         .gt        (gts[i])
      );
   end

endmodule

[src/stable_insertion_sorter_top.sv]
// Stable ascending sorter for one batch of up to CAPACITY records.
// req_chan carries one record per beat: item_handle, sort_key (Q16.16) and
// batch_end on the last record of the batch. rsp_chan returns the batch in
// ascending key order, equal keys in arrival order, final_flag on the last
// beat and overflow_flag on every beat of a batch that lost records.
// Records are inserted by a row of compare-and-shift cells: the new key is
// compared in every cell at once, so one record goes in each cycle and
// req_chan.ready stays high while a batch is being collected.
// Records that arrive while all cells are full are dropped.
// After the beat with batch_end, req_chan.ready drops and the first result is
// offered on the next cycle; the batch drains one beat per cycle while the
// receiver is ready, by shifting the row toward its head. A stalled receiver
// holds the head beat and the row in place. After the final beat the block
// takes input again in the next cycle.
// Reset (synchronous, active high) empties the row, clears the drop mark and
// returns to collecting; no clearing pass is needed.
module stable_insertion_sorter_top import ssis_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   ssis_req_if.sink   req_chan,
   ssis_rsp_if.source rsp_chan
);

   state_type     state_ff, state_in;
   count_type     count_ff, count_in;
   logic          dropped_ff, dropped_in;
   logic          req_fire;
   logic          rsp_fire;
   logic          full;
   logic          last_beat;
   cell_ctrl_type ctrl;
   rec_type       head;

   assign full      = (count_ff == COUNT_BITS'(CAPACITY));
   assign req_fire  = req_chan.valid && req_chan.ready;
   assign rsp_fire  = rsp_chan.valid && rsp_chan.ready;
   assign last_beat = (count_ff == COUNT_BITS'(1));

   assign ctrl.insert = req_fire && !full;
   assign ctrl.shift  = rsp_fire;
   assign ctrl.key    = to_key(req_chan.sort_key);
   assign ctrl.handle = req_chan.item_handle;

   ssis_chain u_chain (
      .clock (clock),
      .reset (reset),
      .ctrl  (ctrl),
      .head  (head)
   );

   assign req_chan.ready         = (state_ff == ST_FILL);
   assign rsp_chan.valid         = (state_ff == ST_DRAIN);
   assign rsp_chan.sorted_handle = head.handle;
   assign rsp_chan.sorted_key    = from_key(head.key);
   assign rsp_chan.final_flag    = last_beat;
   assign rsp_chan.overflow_flag = dropped_ff;

   always_comb begin
      state_in   = state_ff;
      count_in   = count_ff;
      dropped_in = dropped_ff;
      case (state_ff)
         ST_FILL: begin
            if (req_fire) begin
               if (full) begin
                  dropped_in = 1'b1;
               end else begin
                  count_in = count_ff + COUNT_BITS'(1);
               end
               if (req_chan.batch_end) begin
                  state_in = ST_DRAIN;
               end
            end
         end
         ST_DRAIN: begin
            if (rsp_fire) begin
               count_in = count_ff - COUNT_BITS'(1);
               if (last_beat) begin
                  state_in   = ST_FILL;
                  dropped_in = 1'b0;
               end
            end
         end
         default: begin
            state_in = ST_FILL;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_FILL;
         count_ff   <= '0;
         dropped_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         count_ff   <= count_in;
         dropped_ff <= dropped_in;
      end
   end

   a_head_valid: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DRAIN |-> head.valid && count_ff != '0)
      else $error("draining with an empty head cell");

   a_end_drains: assert property (@(posedge clock) disable iff (reset)
      req_fire && req_chan.batch_end |=> state_ff == ST_DRAIN)
      else $error("batch end did not start the drain");

   a_final_empties: assert property (@(posedge clock) disable iff (reset)
      rsp_fire && rsp_chan.final_flag |=> count_ff == '0 && !head.valid && !dropped_ff)
      else $error("row not empty after final beat");

   a_drop_only_full: assert property (@(posedge clock) disable iff (reset)
      $rose(dropped_ff) |-> $past(full))
      else $error("drop mark set with room in the row");

endmodule

[sim/tb.sv]
`timescale 1ns / 1ps

module tb import ssis_pkg::*;;

   localparam int ITEMS_TARGET = 320;
   localparam int DRAIN_LIMIT  = 100000;

   typedef struct {
      handle_type    handle;
      key_field_type key;
      logic          final_beat;
      logic          overflow;
   } sorted_beat_type;

   logic clock;
   logic reset;

   ssis_req_if req_bus ();
   ssis_rsp_if rsp_bus ();

   stable_insertion_sorter_top dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus)
   );

   // shadow of the sorted row
   key_type    row_key [CAPACITY];
   handle_type row_handle [CAPACITY];
   int         row_count;
   bit         row_lost;

   sorted_beat_type pending_sorted[$];

   int  mismatch_count;
   int  results_seen;
   int  records_sent;
   int  batches_done;
   int  overflow_batches;
   bit  steady_send;

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin
      #5_000_000;
      $display("Regression FAIL");
      $finish;
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic key_field_type pick_key(int mode);
      case (mode)
         0: return $urandom();
         1: return $urandom_range(0, 7);
         2: return (32'($urandom_range(0, 255)) << 16) | ($urandom() & 32'h0000_FFFF);
         default: return 32'hFFFF_FFF8 | $urandom_range(0, 7);
      endcase
   endfunction

   // Insert one accepted record; on batch end, queue the whole sorted batch.
   function automatic void shadow_insert(handle_type h, key_field_type k, logic last);
      key_type         kk;
      int              pos;
      sorted_beat_type beat;
      kk = key_type'(k);
      if (row_count < CAPACITY) begin
         pos = row_count;
         while (pos > 0 && row_key[pos-1] > kk) begin
            row_key[pos]    = row_key[pos-1];
            row_handle[pos] = row_handle[pos-1];
            pos--;
         end
         row_key[pos]    = kk;
         row_handle[pos] = h;
         row_count++;
      end else begin
         row_lost = 1'b1;
      end
      if (last) begin
         for (int i = 0; i < row_count; i++) begin
            beat.handle     = row_handle[i];
            beat.key        = key_field_type'(row_key[i]);
            beat.final_beat = (i == row_count - 1);
            beat.overflow   = row_lost;
            pending_sorted.insert(pending_sorted.size(), beat);
         end
         batches_done++;
         if (row_lost) overflow_batches++;
         row_count = 0;
         row_lost  = 1'b0;
      end
   endfunction

   task automatic send_record(input handle_type h, input key_field_type k, input logic last);
      int gap;
      gap = steady_send ? 0 : pick_gap();
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid       <= 1'b1;
      req_bus.item_handle <= h;
      req_bus.sort_key    <= k;
      req_bus.batch_end   <= last;
      do @(posedge clock); while (!req_bus.ready);
      shadow_insert(h, k, last);
      records_sent++;
   endtask

   task automatic send_random_batch(input int n, input int key_mode);
      for (int i = 0; i < n; i++)
         send_record(handle_type'($urandom()), pick_key(key_mode), i == n - 1);
   endtask

   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (got !== want) begin
         mismatch_count++;
         if (mismatch_count <= 10)
            $display("mismatch in %s at result %0d: expected %h, got %h",
                     name, results_seen, want, got);
      end
   endtask

   // result checker
   always @(posedge clock) begin
      sorted_beat_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         results_seen++;
         if (pending_sorted.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("unexpected result %0d: handle %h key %h final %b overflow %b",
                        results_seen, rsp_bus.sorted_handle, rsp_bus.sorted_key,
                        rsp_bus.final_flag, rsp_bus.overflow_flag);
         end else begin
            want = pending_sorted.pop_front();
            check_field("sorted_handle", 32'(want.handle), 32'(rsp_bus.sorted_handle));
            check_field("sorted_key", want.key, rsp_bus.sorted_key);
            check_field("final_flag", 32'(want.final_beat), 32'(rsp_bus.final_flag));
            check_field("overflow_flag", 32'(want.overflow), 32'(rsp_bus.overflow_flag));
         end
      end
   end

   // receiver: runs of ready, random stalls, some stall-free stretches
   initial begin
      rsp_bus.ready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if ($urandom_range(0, 3) == 0) begin
            rsp_bus.ready <= 1'b1;
            repeat ($urandom_range(20, 80)) @(posedge clock);
         end else begin
            rsp_bus.ready <= 1'b1;
            repeat ($urandom_range(1, 6)) @(posedge clock);
            rsp_bus.ready <= 1'b0;
            repeat (pick_gap() + 1) @(posedge clock);
         end
      end
   end

   task automatic test_single_records();
      send_record(16'h0000, 32'h0000_0000, 1'b1);
      send_record(16'hFFFF, 32'hFFFF_FFFF, 1'b1);
   endtask

   task automatic test_key_extremes();
      send_record(16'hFFFF, 32'hFFFF_FFFF, 1'b0);
      send_record(16'h0000, 32'h0000_0000, 1'b0);
      send_record(16'hAAAA, 32'h8000_0000, 1'b0);
      send_record(16'h5555, 32'h7FFF_FFFF, 1'b0);
      send_record(16'h8001, 32'h0001_0000, 1'b0);
      send_record(16'h7FFE, 32'h0000_0001, 1'b1);
   endtask

   // equal keys must come out in arrival order
   task automatic test_equal_keys();
      for (int i = 0; i < 5; i++)
         send_record(handle_type'(16'h0100 + i), 32'h0002_8000, i == 4);
      for (int i = 0; i < 6; i++)
         send_record(handle_type'(16'h0200 + i), (i % 2) ? 32'h0000_0010 : 32'h0000_0008,
                     i == 5);
   endtask

   task automatic test_descending();
      for (int i = 0; i < 6; i++)
         send_record(handle_type'(16'h0300 + i), 32'h0006_0000 - 32'(i) * 32'h0001_0000,
                     i == 5);
   endtask

   task automatic test_full_store();
      send_random_batch(CAPACITY, 0);
   endtask

   // store full before batch end: extra records and the end record are dropped
   task automatic test_overflow();
      send_random_batch(CAPACITY + 3, 2);
      send_random_batch(3, 1);
   endtask

   task automatic test_random_batches();
      int r;
      int n;
      while (records_sent < ITEMS_TARGET) begin
         r = $urandom_range(0, 99);
         if (r < 70)      n = $urandom_range(1, 8);
         else if (r < 92) n = $urandom_range(9, 24);
         else             n = $urandom_range(CAPACITY - 4, CAPACITY + 6);
         steady_send = ($urandom_range(0, 9) < 3);
         send_random_batch(n, $urandom_range(0, 3));
      end
      steady_send = 1'b0;
   endtask

   initial begin
      int waited;
      reset                <= 1'b1;
      req_bus.valid        <= 1'b0;
      req_bus.item_handle  <= '0;
      req_bus.sort_key     <= '0;
      req_bus.batch_end    <= 1'b0;
      row_count        = 0;
      row_lost         = 1'b0;
      mismatch_count   = 0;
      results_seen     = 0;
      records_sent     = 0;
      batches_done     = 0;
      overflow_batches = 0;
      steady_send      = 1'b0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_single_records();
      test_key_extremes();
      test_equal_keys();
      test_descending();
      test_full_store();
      test_overflow();
      test_random_batches();
      req_bus.valid <= 1'b0;

      waited = 0;
      while (pending_sorted.size() != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      repeat (16) @(posedge clock);
      if (pending_sorted.size() != 0) begin
         $display("%0d expected results never arrived", pending_sorted.size());
         mismatch_count += pending_sorted.size();
      end

      $display("Sorted %0d batches from %0d records, %0d of them with dropped records;",
               batches_done, records_sent, overflow_batches);
      $display("%0d result beats checked, %0d mismatches.", results_seen, mismatch_count);
      if (mismatch_count == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule

[stable_insertion_sorter_top.f]
src/ssis_pkg.sv
src/ssis_if.sv
src/ssis_cell.sv
src/ssis_chain.sv
src/stable_insertion_sorter_top.sv
sim/tb.sv
